>>> hdl/rmch_pkg.sv
`timescale 1ns / 1ps
// Package for the ray / mesh closest hit block: shared types, constants,
// register codes and the quotient compare used by the back end. No dependencies.
package rmch_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int INDEX_BITS_DEF = 24;
	localparam int DIR_BITS       = 32;
	localparam int DIST_BITS      = 31;
	localparam int BARY_BITS      = 32;
	localparam int CFG_INDEX_BITS = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int Q_BITS         = 33;
	localparam int FRAC_BITS      = 30;
	localparam int MAC_STEPS      = 24;
	localparam int DET_EPS        = 5;

	localparam logic [Q_BITS-1:0] ONE_Q30  = 33'h0_4000_0000;
	localparam logic [Q_BITS-1:0] BARY_TOL = 33'h0_0000_0001;
	localparam logic [Q_BITS-1:0] BARY_HI  = 33'h0_4000_0001;
	localparam logic [Q_BITS-1:0] DIST_MAX = 33'h0_7FFF_FFFF;

	localparam logic signed [DIR_BITS-1:0] DIR_X_RESET = 32'sh4000_0000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ORIGIN_X     = 4'd0,
		REG_ORIGIN_Y     = 4'd1,
		REG_ORIGIN_Z     = 4'd2,
		REG_DIR_X        = 4'd3,
		REG_DIR_Y        = 4'd4,
		REG_DIR_Z        = 4'd5,
		REG_MIN_DISTANCE = 4'd6,
		REG_SKIP_INDEX   = 4'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_NORM,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_P0,
		DST_P1,
		DST_P2,
		DST_R0,
		DST_R1,
		DST_R2,
		DST_DET,
		DST_NU,
		DST_NV,
		DST_NT
	} dst_t;

	typedef enum logic [1:0] {
		DIV_U = 2'd0,
		DIV_V = 2'd1,
		DIV_S = 2'd2,
		DIV_T = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic signed [DIR_BITS-1:0] dir_x;
		logic signed [DIR_BITS-1:0] dir_y;
		logic signed [DIR_BITS-1:0] dir_z;
		logic [DIST_BITS-1:0]       min_distance;
	} back_cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic              neg;
		logic              big;
		logic [Q_BITS-1:0] mag;
		logic              rem;
	} quot_t;

	function automatic logic mag_gt(input quot_t a, input logic [Q_BITS-1:0] k);
		return a.big || (a.mag > k) || ((a.mag == k) && a.rem);
	endfunction

endpackage

>>> hdl/rmch_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the closest hit block: configuration writes, triangle
// transactions and result transactions. Depends on rmch_pkg.
interface rmch_cfg_if #(parameter int DATA_BITS = 32);
	logic                                valid;
	logic                                ready;
	logic [rmch_pkg::CFG_INDEX_BITS-1:0] index;
	logic [DATA_BITS-1:0]                data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface rmch_tri_if #(parameter int COORD_BITS = 32, parameter int INDEX_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] a_z;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] b_z;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] c_z;
	logic [INDEX_BITS-1:0]        tri_index;
	logic                         last_tri;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		tri_index, last_tri, input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		tri_index, last_tri, output ready);
endinterface

interface rmch_hit_if #(parameter int INDEX_BITS = 24);
	logic                                   valid;
	logic                                   ready;
	logic                                   hit_found;
	logic [rmch_pkg::DIST_BITS-1:0]         hit_distance;
	logic [INDEX_BITS-1:0]                  hit_index;
	logic signed [rmch_pkg::BARY_BITS-1:0]  hit_u;
	logic signed [rmch_pkg::BARY_BITS-1:0]  hit_v;
	modport source(output valid, hit_found, hit_distance, hit_index, hit_u, hit_v,
		input ready);
	modport sink(input valid, hit_found, hit_distance, hit_index, hit_u, hit_v,
		output ready);
endinterface

>>> hdl/rmch_front.sv
`timescale 1ns / 1ps
// Front end: ray configuration registers, triangle acceptance, skip check and
// edge / origin differences pushed to the queue. Depends on rmch_pkg, rmch_if.
module rmch_front #(
	parameter int COORD_BITS = rmch_pkg::COORD_BITS_DEF,
	parameter int INDEX_BITS = rmch_pkg::INDEX_BITS_DEF,
	parameter int DATA_BITS  = 32,
	parameter int ENTRY_BITS = 9 * (COORD_BITS + 1) + INDEX_BITS + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rmch_cfg_if.sink              cfg,
	rmch_tri_if.sink              triangle,
	input  rmch_pkg::fifo_stat_t  qstat,
	output logic                  push,
	output logic [ENTRY_BITS-1:0] push_data,
	output rmch_pkg::back_cfg_t   ray
);

	localparam int EW = COORD_BITS + 1;

	logic signed [COORD_BITS-1:0]         org_x_q, org_y_q, org_z_q;
	logic signed [rmch_pkg::DIR_BITS-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic [rmch_pkg::DIST_BITS-1:0]       min_q;
	logic [INDEX_BITS-1:0]                skip_q;

	logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, qx, qy, qz;
	logic                 skip;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			dir_x_q <= rmch_pkg::DIR_X_RESET;
			dir_y_q <= '0;
			dir_z_q <= '0;
			min_q   <= '0;
			skip_q  <= '1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				rmch_pkg::REG_ORIGIN_X:     org_x_q <= cfg.data[COORD_BITS-1:0];
				rmch_pkg::REG_ORIGIN_Y:     org_y_q <= cfg.data[COORD_BITS-1:0];
				rmch_pkg::REG_ORIGIN_Z:     org_z_q <= cfg.data[COORD_BITS-1:0];
				rmch_pkg::REG_DIR_X:        dir_x_q <= cfg.data[rmch_pkg::DIR_BITS-1:0];
				rmch_pkg::REG_DIR_Y:        dir_y_q <= cfg.data[rmch_pkg::DIR_BITS-1:0];
				rmch_pkg::REG_DIR_Z:        dir_z_q <= cfg.data[rmch_pkg::DIR_BITS-1:0];
				rmch_pkg::REG_MIN_DISTANCE: min_q   <= cfg.data[rmch_pkg::DIST_BITS-1:0];
				rmch_pkg::REG_SKIP_INDEX:   skip_q  <= cfg.data[INDEX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign ray.dir_x        = dir_x_q;
	assign ray.dir_y        = dir_y_q;
	assign ray.dir_z        = dir_z_q;
	assign ray.min_distance = min_q;

	assign e1x = EW'(triangle.b_x) - EW'(triangle.a_x);
	assign e1y = EW'(triangle.b_y) - EW'(triangle.a_y);
	assign e1z = EW'(triangle.b_z) - EW'(triangle.a_z);
	assign e2x = EW'(triangle.c_x) - EW'(triangle.a_x);
	assign e2y = EW'(triangle.c_y) - EW'(triangle.a_y);
	assign e2z = EW'(triangle.c_z) - EW'(triangle.a_z);
	assign qx  = EW'(org_x_q) - EW'(triangle.a_x);
	assign qy  = EW'(org_y_q) - EW'(triangle.a_y);
	assign qz  = EW'(org_z_q) - EW'(triangle.a_z);
	assign skip = (triangle.tri_index == skip_q);

	assign triangle.ready = !qstat.full;
	assign push           = triangle.valid && !qstat.full;
	assign push_data      = {triangle.last_tri, skip, triangle.tri_index,
		qz, qy, qx, e2z, e2y, e2x, e1z, e1y, e1x};

endmodule

>>> hdl/rmch_fifo.sv
`timescale 1ns / 1ps
// Short register queue between front and back end.
// Depends on rmch_pkg for the status struct.
module rmch_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = rmch_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     pop_data,
	output rmch_pkg::fifo_stat_t stat
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNTW'(DEPTH));
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/rmch_back.sv
`timescale 1ns / 1ps
// Back end: bit-serial multiply-accumulate sequencer for the cross and dot
// products, restoring divider for u, v, u+v and t, nearest-hit keeping and
// the result register. Depends on rmch_pkg, rmch_if.
module rmch_back #(
	parameter int COORD_BITS = rmch_pkg::COORD_BITS_DEF,
	parameter int INDEX_BITS = rmch_pkg::INDEX_BITS_DEF,
	parameter int ENTRY_BITS = 9 * (COORD_BITS + 1) + INDEX_BITS + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmch_pkg::back_cfg_t   ray,
	input  logic [ENTRY_BITS-1:0] ent,
	input  rmch_pkg::fifo_stat_t  qstat,
	output logic                  pop,
	rmch_hit_if.source            hit
);

	localparam int EW   = COORD_BITS + 1;
	localparam int AW   = (EW > rmch_pkg::DIR_BITS) ? EW : rmch_pkg::DIR_BITS;
	localparam int WA   = 3 * COORD_BITS + 7;
	localparam int WB   = 2 * COORD_BITS + 38;
	localparam int WW   = (WA > WB) ? WA : WB;
	localparam int DW   = WW + rmch_pkg::Q_BITS;
	localparam int BW   = $clog2(AW);
	localparam int SW   = $clog2(rmch_pkg::MAC_STEPS);
	localparam int CW   = $clog2(rmch_pkg::Q_BITS + 1);
	localparam int QB   = rmch_pkg::Q_BITS;
	localparam int DB   = rmch_pkg::DIST_BITS;
	localparam int XB   = rmch_pkg::BARY_BITS;

	rmch_pkg::state_t   state_q, state_d;
	logic [SW-1:0]      step_q;
	logic [BW-1:0]      bit_q;
	rmch_pkg::div_sel_t div_q;
	logic [CW-1:0]      cnt_q;

	logic pop_en, mac_en, norm_en, dload_en, drun_en, decide_en, fin_en, out_load;

	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [EW-1:0] q_q  [3];
	logic [INDEX_BITS-1:0] idx_q;
	logic                  last_q;
	logic                  ent_skip;

	logic signed [WW-1:0] p_q [3];
	logic signed [WW-1:0] r_q [3];
	logic signed [WW-1:0] det_q, nu_q, nv_q, nt_q;
	logic signed [WW-1:0] acc_q, bsh_q;

	logic [DW-1:0]     rem_q, dsh_q, rem_nx;
	logic [QB-1:0]     qt_q;
	logic              big_q, dneg_q;
	rmch_pkg::quot_t   quot_q [4];

	logic                  best_valid_q;
	logic [DB-1:0]         best_dist_q;
	logic [INDEX_BITS-1:0] best_idx_q;
	logic [XB-1:0]         best_u_q, best_v_q;

	logic                  hit_valid_q;
	logic                  hit_found_q;
	logic [DB-1:0]         hit_dist_q;
	logic [INDEX_BITS-1:0] hit_idx_q;
	logic [XB-1:0]         hit_u_q, hit_v_q;

	logic signed [AW-1:0] a_v;
	logic signed [WW-1:0] b_v, bsh_cur, term, base, acc_nx;
	logic                 sub, clr, bit_last, mac_done;
	rmch_pkg::dst_t       dst;

	logic signed [WW-1:0] det_abs, num;
	logic [WW-1:0]        nmag;
	logic                 det_small, ge, out_free;
	logic                 u_bad, v_bad, s_bad, t_bad, ok, closer;

	assign ent_skip = ent[9 * EW + INDEX_BITS];
	assign out_free = !hit_valid_q || hit.ready;
	assign bit_last = (bit_q == BW'(AW - 1));
	assign mac_done = bit_last && (step_q == SW'(rmch_pkg::MAC_STEPS - 1));
	assign det_abs  = det_q[WW-1] ? -det_q : det_q;
	assign det_small = (det_abs < WW'(rmch_pkg::DET_EPS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmch_pkg::ST_IDLE: begin
				if (!qstat.empty) begin
					state_d = ent_skip ? rmch_pkg::ST_FINISH : rmch_pkg::ST_MAC;
				end
			end
			rmch_pkg::ST_MAC: begin
				if (mac_done) begin
					state_d = rmch_pkg::ST_NORM;
				end
			end
			rmch_pkg::ST_NORM: begin
				state_d = det_small ? rmch_pkg::ST_FINISH : rmch_pkg::ST_DIV_LOAD;
			end
			rmch_pkg::ST_DIV_LOAD: begin
				state_d = rmch_pkg::ST_DIV_RUN;
			end
			rmch_pkg::ST_DIV_RUN: begin
				if (cnt_q == '0) begin
					state_d = (div_q == rmch_pkg::DIV_T) ? rmch_pkg::ST_DECIDE
						: rmch_pkg::ST_DIV_LOAD;
				end
			end
			rmch_pkg::ST_DECIDE: begin
				state_d = rmch_pkg::ST_FINISH;
			end
			rmch_pkg::ST_FINISH: begin
				if (!last_q || out_free) begin
					state_d = rmch_pkg::ST_IDLE;
				end
			end
			default: state_d = rmch_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop_en    = 1'b0;
		mac_en    = 1'b0;
		norm_en   = 1'b0;
		dload_en  = 1'b0;
		drun_en   = 1'b0;
		decide_en = 1'b0;
		fin_en    = 1'b0;
		unique case (state_q)
			rmch_pkg::ST_IDLE:     pop_en    = !qstat.empty;
			rmch_pkg::ST_MAC:      mac_en    = 1'b1;
			rmch_pkg::ST_NORM:     norm_en   = 1'b1;
			rmch_pkg::ST_DIV_LOAD: dload_en  = 1'b1;
			rmch_pkg::ST_DIV_RUN:  drun_en   = 1'b1;
			rmch_pkg::ST_DECIDE:   decide_en = 1'b1;
			rmch_pkg::ST_FINISH:   fin_en    = 1'b1;
			default: begin
			end
		endcase
	end

	assign pop      = pop_en;
	assign out_load = fin_en && last_q && out_free;

	// multiply-accumulate program
	always_comb begin
		a_v = '0;
		b_v = '0;
		sub = 1'b0;
		clr = 1'b0;
		dst = rmch_pkg::DST_NONE;
		unique case (step_q)
			5'd0:  begin a_v = AW'(ray.dir_y); b_v = WW'(e2_q[2]); clr = 1'b1; end
			5'd1:  begin a_v = AW'(ray.dir_z); b_v = WW'(e2_q[1]); sub = 1'b1;
				dst = rmch_pkg::DST_P0; end
			5'd2:  begin a_v = AW'(ray.dir_z); b_v = WW'(e2_q[0]); clr = 1'b1; end
			5'd3:  begin a_v = AW'(ray.dir_x); b_v = WW'(e2_q[2]); sub = 1'b1;
				dst = rmch_pkg::DST_P1; end
			5'd4:  begin a_v = AW'(ray.dir_x); b_v = WW'(e2_q[1]); clr = 1'b1; end
			5'd5:  begin a_v = AW'(ray.dir_y); b_v = WW'(e2_q[0]); sub = 1'b1;
				dst = rmch_pkg::DST_P2; end
			5'd6:  begin a_v = AW'(q_q[1]); b_v = WW'(e1_q[2]); clr = 1'b1; end
			5'd7:  begin a_v = AW'(q_q[2]); b_v = WW'(e1_q[1]); sub = 1'b1;
				dst = rmch_pkg::DST_R0; end
			5'd8:  begin a_v = AW'(q_q[2]); b_v = WW'(e1_q[0]); clr = 1'b1; end
			5'd9:  begin a_v = AW'(q_q[0]); b_v = WW'(e1_q[2]); sub = 1'b1;
				dst = rmch_pkg::DST_R1; end
			5'd10: begin a_v = AW'(q_q[0]); b_v = WW'(e1_q[1]); clr = 1'b1; end
			5'd11: begin a_v = AW'(q_q[1]); b_v = WW'(e1_q[0]); sub = 1'b1;
				dst = rmch_pkg::DST_R2; end
			5'd12: begin a_v = AW'(e1_q[0]); b_v = p_q[0]; clr = 1'b1; end
			5'd13: begin a_v = AW'(e1_q[1]); b_v = p_q[1]; end
			5'd14: begin a_v = AW'(e1_q[2]); b_v = p_q[2]; dst = rmch_pkg::DST_DET; end
			5'd15: begin a_v = AW'(q_q[0]); b_v = p_q[0]; clr = 1'b1; end
			5'd16: begin a_v = AW'(q_q[1]); b_v = p_q[1]; end
			5'd17: begin a_v = AW'(q_q[2]); b_v = p_q[2]; dst = rmch_pkg::DST_NU; end
			5'd18: begin a_v = AW'(ray.dir_x); b_v = r_q[0]; clr = 1'b1; end
			5'd19: begin a_v = AW'(ray.dir_y); b_v = r_q[1]; end
			5'd20: begin a_v = AW'(ray.dir_z); b_v = r_q[2]; dst = rmch_pkg::DST_NV; end
			5'd21: begin a_v = AW'(e2_q[0]); b_v = r_q[0]; clr = 1'b1; end
			5'd22: begin a_v = AW'(e2_q[1]); b_v = r_q[1]; end
			5'd23: begin a_v = AW'(e2_q[2]); b_v = r_q[2]; dst = rmch_pkg::DST_NT; end
			default: begin
			end
		endcase
	end

	assign bsh_cur = (bit_q == '0) ? b_v : bsh_q;
	assign term    = a_v[bit_q] ? bsh_cur : '0;
	assign base    = ((bit_q == '0) && clr) ? '0 : acc_q;
	assign acc_nx  = (sub ^ bit_last) ? base - term : base + term;

	// divider operands
	always_comb begin
		case (div_q)
			rmch_pkg::DIV_U: num = nu_q;
			rmch_pkg::DIV_V: num = nv_q;
			rmch_pkg::DIV_S: num = nu_q + nv_q;
			default:         num = nt_q;
		endcase
	end

	assign nmag   = num[WW-1] ? WW'(-num) : WW'(num);
	assign ge     = (rem_q >= dsh_q);
	assign rem_nx = ge ? rem_q - dsh_q : rem_q;

	// hit tests
	always_comb begin
		u_bad = quot_q[0].neg ? rmch_pkg::mag_gt(quot_q[0], rmch_pkg::BARY_TOL)
			: rmch_pkg::mag_gt(quot_q[0], rmch_pkg::BARY_HI);
		v_bad = quot_q[1].neg && rmch_pkg::mag_gt(quot_q[1], rmch_pkg::BARY_TOL);
		s_bad = !quot_q[2].neg && rmch_pkg::mag_gt(quot_q[2], rmch_pkg::BARY_HI);
		t_bad = quot_q[3].neg
			|| !rmch_pkg::mag_gt(quot_q[3], QB'(ray.min_distance))
			|| quot_q[3].big || (quot_q[3].mag > rmch_pkg::DIST_MAX);
		ok     = !(u_bad || v_bad || s_bad || t_bad);
		closer = !best_valid_q || (quot_q[3].mag[DB-1:0] < best_dist_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rmch_pkg::ST_IDLE;
			step_q       <= '0;
			bit_q        <= '0;
			div_q        <= rmch_pkg::DIV_U;
			cnt_q        <= '0;
			best_valid_q <= 1'b0;
			hit_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop_en) begin
				step_q <= '0;
				bit_q  <= '0;
			end
			if (mac_en) begin
				if (bit_last) begin
					bit_q  <= '0;
					step_q <= step_q + 1'b1;
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
			if (norm_en) begin
				div_q <= rmch_pkg::DIV_U;
			end
			if (dload_en) begin
				cnt_q <= CW'(QB);
			end
			if (drun_en) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					div_q <= rmch_pkg::div_sel_t'(div_q + 2'd1);
				end
			end
			if (decide_en && ok && closer) begin
				best_valid_q <= 1'b1;
			end else if (out_load) begin
				best_valid_q <= 1'b0;
			end
			if (out_load) begin
				hit_valid_q <= 1'b1;
			end else if (hit.ready) begin
				hit_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_en) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= ent[k * EW +: EW];
				e2_q[k] <= ent[(3 + k) * EW +: EW];
				q_q[k]  <= ent[(6 + k) * EW +: EW];
			end
			idx_q  <= ent[9 * EW +: INDEX_BITS];
			last_q <= ent[9 * EW + INDEX_BITS + 1];
		end
		if (mac_en) begin
			acc_q <= acc_nx;
			bsh_q <= bsh_cur <<< 1;
			if (bit_last) begin
				unique case (dst)
					rmch_pkg::DST_P0:  p_q[0] <= acc_nx;
					rmch_pkg::DST_P1:  p_q[1] <= acc_nx;
					rmch_pkg::DST_P2:  p_q[2] <= acc_nx;
					rmch_pkg::DST_R0:  r_q[0] <= acc_nx;
					rmch_pkg::DST_R1:  r_q[1] <= acc_nx;
					rmch_pkg::DST_R2:  r_q[2] <= acc_nx;
					rmch_pkg::DST_DET: det_q  <= acc_nx;
					rmch_pkg::DST_NU:  nu_q   <= acc_nx;
					rmch_pkg::DST_NV:  nv_q   <= acc_nx;
					rmch_pkg::DST_NT:  nt_q   <= acc_nx;
					default: begin
					end
				endcase
			end
		end
		if (norm_en && det_q[WW-1]) begin
			det_q <= -det_q;
			nu_q  <= -nu_q;
			nv_q  <= -nv_q;
			nt_q  <= -nt_q;
		end
		if (dload_en) begin
			rem_q  <= DW'(nmag) << rmch_pkg::FRAC_BITS;
			dsh_q  <= DW'(det_q) << QB;
			dneg_q <= num[WW-1];
			qt_q   <= '0;
		end
		if (drun_en) begin
			dsh_q <= dsh_q >> 1;
			if (cnt_q == CW'(QB)) begin
				big_q <= ge;
			end else begin
				rem_q <= rem_nx;
				qt_q  <= {qt_q[QB-2:0], ge};
			end
			if (cnt_q == '0) begin
				quot_q[div_q] <= '{neg: dneg_q, big: big_q, mag: {qt_q[QB-2:0], ge},
					rem: (rem_nx != '0)};
			end
		end
		if (decide_en && ok && closer) begin
			best_dist_q <= quot_q[3].mag[DB-1:0];
			best_idx_q  <= idx_q;
			best_u_q    <= quot_q[0].neg ? XB'(-quot_q[0].mag[XB-1:0]) : quot_q[0].mag[XB-1:0];
			best_v_q    <= quot_q[1].neg ? XB'(-quot_q[1].mag[XB-1:0]) : quot_q[1].mag[XB-1:0];
		end
		if (out_load) begin
			hit_found_q <= best_valid_q;
			hit_dist_q  <= best_valid_q ? best_dist_q : '0;
			hit_idx_q   <= best_valid_q ? best_idx_q : '0;
			hit_u_q     <= best_valid_q ? best_u_q : '0;
			hit_v_q     <= best_valid_q ? best_v_q : '0;
		end
	end

	assign hit.valid        = hit_valid_q;
	assign hit.hit_found    = hit_found_q;
	assign hit.hit_distance = hit_dist_q;
	assign hit.hit_index    = hit_idx_q;
	assign hit.hit_u        = hit_u_q;
	assign hit.hit_v        = hit_v_q;

endmodule

>>> hdl/ray_mesh_closest_hit_top.sv
`timescale 1ns / 1ps
// Nearest ray / triangle hit over a streamed mesh.
// Channels: cfg writes the ray (origin, direction, minimum distance, skipped
// index) by register index, always ready; write it only while the block idles.
// triangle carries one triangle per transaction, last_tri closes the mesh.
// hit carries one result transaction per mesh, after its last triangle.
// Each triangle runs 24 bit-serial multiply-accumulate passes over AW-bit
// multipliers, AW = max(COORD_BITS+1, 32), then four restoring divisions.
// A near-flat triangle leaves after the products, a skipped one before them.
// A two-entry queue lets the next triangles be taken during that work, and the
// result register lets work go on while a result waits.
// A stalled receiver holds the result; the last triangle of the next mesh then
// waits until the result is taken. Reset clears the queue, the kept hit and the
// result register, and sets the ray registers to their reset values.
// Depends on rmch_pkg, rmch_if, rmch_front, rmch_fifo, rmch_back.
module ray_mesh_closest_hit_top #(
	parameter int COORD_BITS = rmch_pkg::COORD_BITS_DEF,
	parameter int INDEX_BITS = rmch_pkg::INDEX_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rmch_cfg_if.sink    cfg,
	rmch_tri_if.sink    triangle,
	rmch_hit_if.source  hit
);

	localparam int ENTRY_BITS = 9 * (COORD_BITS + 1) + INDEX_BITS + 2;
	localparam int DATA_BITS  = (COORD_BITS > 32) ? COORD_BITS : 32;

	logic                  push, pop;
	logic [ENTRY_BITS-1:0] push_data, pop_data;
	rmch_pkg::fifo_stat_t  qstat;
	rmch_pkg::back_cfg_t   ray;

	rmch_front #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS),
		.DATA_BITS (DATA_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.triangle (triangle),
		.qstat    (qstat),
		.push     (push),
		.push_data(push_data),
		.ray      (ray)
	);

	rmch_fifo #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(rmch_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (qstat)
	);

	rmch_back #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.ray   (ray),
		.ent   (pop_data),
		.qstat (qstat),
		.pop   (pop),
		.hit   (hit)
	);

endmodule

>>> hdl/rmch_checker.sv
`timescale 1ns / 1ps
// Port checker for the closest hit block, bound to the top level.
// Depends on rmch_pkg and ray_mesh_closest_hit_top.
module rmch_checker #(
	parameter int INDEX_BITS = rmch_pkg::INDEX_BITS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cfg_ready,
	input logic                                  hit_valid,
	input logic                                  hit_ready,
	input logic                                  hit_found,
	input logic [rmch_pkg::DIST_BITS-1:0]        hit_distance,
	input logic [INDEX_BITS-1:0]                 hit_index,
	input logic signed [rmch_pkg::BARY_BITS-1:0] hit_u,
	input logic signed [rmch_pkg::BARY_BITS-1:0] hit_v
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=> hit_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=> $stable(hit_found) && $stable(hit_distance)
		&& $stable(hit_index) && $stable(hit_u) && $stable(hit_v))
		else $error("stalled result changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_found |-> (hit_distance == '0) && (hit_index == '0)
		&& (hit_u == '0) && (hit_v == '0))
		else $error("miss result carries non-zero fields");

	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_found |-> (hit_u >= -32'sd1) && (hit_u <= 32'sd1073741825)
		&& (hit_v >= -32'sd1))
		else $error("barycentric outside tolerance");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind ray_mesh_closest_hit_top rmch_checker #(.INDEX_BITS(INDEX_BITS)) u_rmch_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_ready   (cfg.ready),
	.hit_valid   (hit.valid),
	.hit_ready   (hit.ready),
	.hit_found   (hit.hit_found),
	.hit_distance(hit.hit_distance),
	.hit_index   (hit.hit_index),
	.hit_u       (hit.hit_u),
	.hit_v       (hit.hit_v)
);

>>> bench/tb_channels.sv
`timescale 1ns / 1ps
// Bench-side item types for the closest hit channels: one triangle transaction
// and one result transaction. No dependencies.
package tb_channels_pkg;

	typedef struct {
		logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
		logic [23:0]        tri_index;
		logic               last_tri;
	} tri_item_t;

	typedef struct {
		logic               hit_found;
		logic [30:0]        hit_distance;
		logic [23:0]        hit_index;
		logic signed [31:0] hit_u;
		logic signed [31:0] hit_v;
	} hit_item_t;
endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ray_mesh_closest_hit_top: streams meshes of triangles
// under several ray settings and checks every nearest-hit transaction against an
// exact wide-integer intersection model. Depends on rmch_pkg, rmch_if, tb_channels.
module tb;

	typedef logic signed [255:0] wide_t;
	typedef struct {
		bit          neg;
		logic [255:0] mag;
		bit          rem;
	} ratio_t;

	logic clk;
	logic arst_n;

	rmch_cfg_if #(.DATA_BITS(32)) cfg_ch();
	rmch_tri_if #(.COORD_BITS(32), .INDEX_BITS(24)) tri_ch();
	rmch_hit_if #(.INDEX_BITS(24)) hit_ch();

	ray_mesh_closest_hit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.triangle(tri_ch),
		.hit(hit_ch)
	);

	// ray shadow
	logic signed [31:0] ray_org [3];
	logic signed [31:0] ray_dir [3];
	logic [30:0]        ray_min;
	logic [23:0]        ray_skip;

	// nearest hit so far
	bit                 near_valid;
	logic [30:0]        near_dist;
	logic [23:0]        near_index;
	logic [31:0]        near_u;
	logic [31:0]        near_v;

	tb_channels_pkg::tri_item_t pending_tris[$];
	tb_channels_pkg::hit_item_t expected_hits[$];
	tb_channels_pkg::tri_item_t cur_tri;
	bit        tri_in_flight;
	int        tri_gap;
	int        hit_stall;
	bit        burst;
	int        errors;
	int        tris_sent;
	int        meshes_seen;
	int        hits_seen;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic ratio_t divide_q30(wide_t num, wide_t den);
		ratio_t o;
		logic [255:0] m;
		logic [255:0] n;
		o.neg = num < 0;
		m = o.neg ? -num : num;
		n = m << 30;
		o.mag = n / den;
		o.rem = (n % den) != 0;
		return o;
	endfunction

	function automatic bit above(ratio_t a, logic [255:0] k);
		return (a.mag > k) || ((a.mag == k) && a.rem);
	endfunction

	function automatic logic [31:0] to_q30(ratio_t a);
		logic [31:0] m;
		m = a.mag[31:0];
		return a.neg ? -m : m;
	endfunction

	task automatic queue_tri(tb_channels_pkg::tri_item_t t);
		pending_tris = {pending_tris, t};
	endtask

	task automatic predict_triangle(tb_channels_pkg::tri_item_t t);
		wide_t va[3], vb[3], vc[3], d[3], e1[3], e2[3], q[3], p[3], r[3];
		wide_t det, nu, nv, nt;
		ratio_t u, v, s, tq;
		bit ok;
		tb_channels_pkg::hit_item_t h;
		ok = 1;
		if (t.tri_index != ray_skip) begin
			va[0] = t.a_x; va[1] = t.a_y; va[2] = t.a_z;
			vb[0] = t.b_x; vb[1] = t.b_y; vb[2] = t.b_z;
			vc[0] = t.c_x; vc[1] = t.c_y; vc[2] = t.c_z;
			for (int i = 0; i < 3; i++) begin
				d[i] = ray_dir[i];
				e1[i] = vb[i] - va[i];
				e2[i] = vc[i] - va[i];
				q[i] = wide_t'(ray_org[i]) - va[i];
			end
			p[0] = d[1] * e2[2] - d[2] * e2[1];
			p[1] = d[2] * e2[0] - d[0] * e2[2];
			p[2] = d[0] * e2[1] - d[1] * e2[0];
			r[0] = q[1] * e1[2] - q[2] * e1[1];
			r[1] = q[2] * e1[0] - q[0] * e1[2];
			r[2] = q[0] * e1[1] - q[1] * e1[0];
			det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
			nu = q[0] * p[0] + q[1] * p[1] + q[2] * p[2];
			nv = d[0] * r[0] + d[1] * r[1] + d[2] * r[2];
			nt = e2[0] * r[0] + e2[1] * r[1] + e2[2] * r[2];
			if (det < 0) begin
				det = -det; nu = -nu; nv = -nv; nt = -nt;
			end
			if (det < rmch_pkg::DET_EPS) ok = 0;
			if (ok) begin
				u = divide_q30(nu, det);
				v = divide_q30(nv, det);
				s = divide_q30(nu + nv, det);
				tq = divide_q30(nt, det);
				if (u.neg ? above(u, rmch_pkg::BARY_TOL) : above(u, rmch_pkg::BARY_HI)) ok = 0;
				if (v.neg && above(v, rmch_pkg::BARY_TOL)) ok = 0;
				if (!s.neg && above(s, rmch_pkg::BARY_HI)) ok = 0;
				if (tq.neg || !above(tq, ray_min) || tq.mag > rmch_pkg::DIST_MAX) ok = 0;
				if (ok && (!near_valid || tq.mag[30:0] < near_dist)) begin
					near_valid = 1;
					near_dist = tq.mag[30:0];
					near_index = t.tri_index;
					near_u = to_q30(u);
					near_v = to_q30(v);
				end
			end
		end
		if (t.last_tri) begin
			h.hit_found = near_valid;
			h.hit_distance = near_valid ? near_dist : '0;
			h.hit_index = near_valid ? near_index : '0;
			h.hit_u = near_valid ? near_u : '0;
			h.hit_v = near_valid ? near_v : '0;
			expected_hits = {expected_hits, h};
			near_valid = 0; near_dist = '0; near_index = '0; near_u = '0; near_v = '0;
		end
	endtask

	// triangle driver
	always @(negedge clk) begin
		if (arst_n && !tri_in_flight) begin
			if (tri_gap > 0) begin
				tri_gap--;
				tri_ch.valid <= 1'b0;
			end else if (pending_tris.size() > 0) begin
				cur_tri = pending_tris.pop_front();
				tri_ch.a_x <= cur_tri.a_x; tri_ch.a_y <= cur_tri.a_y; tri_ch.a_z <= cur_tri.a_z;
				tri_ch.b_x <= cur_tri.b_x; tri_ch.b_y <= cur_tri.b_y; tri_ch.b_z <= cur_tri.b_z;
				tri_ch.c_x <= cur_tri.c_x; tri_ch.c_y <= cur_tri.c_y; tri_ch.c_z <= cur_tri.c_z;
				tri_ch.tri_index <= cur_tri.tri_index;
				tri_ch.last_tri <= cur_tri.last_tri;
				tri_ch.valid <= 1'b1;
				tri_in_flight = 1;
			end else begin
				tri_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (tri_ch.valid && tri_ch.ready && tri_in_flight) begin
			predict_triangle(cur_tri);
			tris_sent++;
			tri_in_flight = 0;
			if ($urandom_range(0, 15) == 0) burst = !burst;
			tri_gap = burst ? 0 : $urandom_range(0, 3);
		end
	end

	// ray register shadow
	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (rmch_pkg::cfg_reg_t'(cfg_ch.index))
				rmch_pkg::REG_ORIGIN_X:     ray_org[0] = cfg_ch.data;
				rmch_pkg::REG_ORIGIN_Y:     ray_org[1] = cfg_ch.data;
				rmch_pkg::REG_ORIGIN_Z:     ray_org[2] = cfg_ch.data;
				rmch_pkg::REG_DIR_X:        ray_dir[0] = cfg_ch.data;
				rmch_pkg::REG_DIR_Y:        ray_dir[1] = cfg_ch.data;
				rmch_pkg::REG_DIR_Z:        ray_dir[2] = cfg_ch.data;
				rmch_pkg::REG_MIN_DISTANCE: ray_min = cfg_ch.data[30:0];
				rmch_pkg::REG_SKIP_INDEX:   ray_skip = cfg_ch.data[23:0];
				default: ;
			endcase
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hit_stall > 0) begin
			hit_stall--;
			hit_ch.ready <= 1'b0;
		end else begin
			hit_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tb_channels_pkg::hit_item_t e;
		if (hit_ch.valid && hit_ch.ready) begin
			meshes_seen++;
			if (hit_ch.hit_found) hits_seen++;
			hit_stall = burst ? 0 : $urandom_range(0, 3);
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected hit transaction found=%0b dist=%h", $time,
					hit_ch.hit_found, hit_ch.hit_distance);
				errors++;
			end else begin
				e = expected_hits.pop_front();
				if (hit_ch.hit_found !== e.hit_found) begin
					$display("%0t: hit_found exp %0b got %0b", $time, e.hit_found, hit_ch.hit_found);
					errors++;
				end
				if (hit_ch.hit_distance !== e.hit_distance) begin
					$display("%0t: hit_distance exp %h got %h", $time, e.hit_distance,
						hit_ch.hit_distance);
					errors++;
				end
				if (hit_ch.hit_index !== e.hit_index) begin
					$display("%0t: hit_index exp %h got %h", $time, e.hit_index, hit_ch.hit_index);
					errors++;
				end
				if (hit_ch.hit_u !== e.hit_u) begin
					$display("%0t: hit_u exp %h got %h", $time, e.hit_u, hit_ch.hit_u);
					errors++;
				end
				if (hit_ch.hit_v !== e.hit_v) begin
					$display("%0t: hit_v exp %h got %h", $time, e.hit_v, hit_ch.hit_v);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(rmch_pkg::cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic write_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
			logic [31:0] dmin, logic [31:0] skip);
		write_reg(rmch_pkg::REG_ORIGIN_X, ox);
		write_reg(rmch_pkg::REG_ORIGIN_Y, oy);
		write_reg(rmch_pkg::REG_ORIGIN_Z, oz);
		write_reg(rmch_pkg::REG_DIR_X, dx);
		write_reg(rmch_pkg::REG_DIR_Y, dy);
		write_reg(rmch_pkg::REG_DIR_Z, dz);
		write_reg(rmch_pkg::REG_MIN_DISTANCE, dmin);
		write_reg(rmch_pkg::REG_SKIP_INDEX, skip);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] q16(real x);
		return $rtoi(x * 65536.0);
	endfunction

	function automatic tb_channels_pkg::tri_item_t make_tri(real ax, real ay, real az,
			real bx, real by, real bz, real cx, real cy, real cz, logic [23:0] idx,
			logic last);
		tb_channels_pkg::tri_item_t t;
		t.a_x = q16(ax); t.a_y = q16(ay); t.a_z = q16(az);
		t.b_x = q16(bx); t.b_y = q16(by); t.b_z = q16(bz);
		t.c_x = q16(cx); t.c_y = q16(cy); t.c_z = q16(cz);
		t.tri_index = idx;
		t.last_tri = last;
		return t;
	endfunction

	function automatic real rnd(real span);
		return (($urandom_range(0, 20000) / 10000.0) - 1.0) * span;
	endfunction

	function automatic tb_channels_pkg::tri_item_t noise_tri();
		tb_channels_pkg::tri_item_t t;
		t.a_x = $urandom; t.a_y = $urandom; t.a_z = $urandom;
		t.b_x = $urandom; t.b_y = $urandom; t.b_z = $urandom;
		t.c_x = $urandom; t.c_y = $urandom; t.c_z = $urandom;
		return t;
	endfunction

	// centroid of the triangle sits on the ray, then jitter pushes some out
	function automatic tb_channels_pkg::tri_item_t aimed_tri();
		tb_channels_pkg::tri_item_t t;
		real h[3], r1[3], r2[3], reach, sz, jit;
		reach = $urandom_range(1, 2000000) / 1000.0;
		sz = $urandom_range(1, 5000) / 10.0;
		jit = ($urandom_range(0, 3) == 0) ? sz : 0.0;
		for (int i = 0; i < 3; i++) begin
			h[i] = ray_org[i] / 65536.0 + reach * (ray_dir[i] / 1073741824.0);
			r1[i] = rnd(sz);
			r2[i] = rnd(sz);
		end
		t = make_tri(h[0] + r1[0], h[1] + r1[1], h[2] + r1[2],
			h[0] + r2[0], h[1] + r2[1], h[2] + r2[2],
			h[0] - r1[0] - r2[0] + rnd(jit), h[1] - r1[1] - r2[1] + rnd(jit),
			h[2] - r1[2] - r2[2] + rnd(jit), '0, 1'b0);
		return t;
	endfunction

	function automatic logic [23:0] pick_index();
		case ($urandom_range(0, 5))
			0: return ray_skip;
			1: return 24'($urandom);
			default: return 24'($urandom_range(0, 40));
		endcase
	endfunction

	task automatic wait_idle();
		while (pending_tris.size() > 0 || tri_in_flight || expected_hits.size() > 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic random_meshes(int count);
		tb_channels_pkg::tri_item_t t, prev;
		int n, len;
		n = 0;
		while (n < count) begin
			len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				if (k > 0 && $urandom_range(0, 9) == 0) t = prev;
				else if ($urandom_range(0, 9) < 7) t = aimed_tri();
				else t = noise_tri();
				t.tri_index = pick_index();
				t.last_tri = (k == len - 1);
				queue_tri(t);
				prev = t;
				n++;
			end
		end
	endtask

	task automatic random_ray(int kind);
		real dv[3], norm;
		logic [31:0] dx, dy, dz, dmin;
		case (kind)
			0: begin
				dx = 0; dy = 0; dz = 0;
				case ($urandom_range(0, 5))
					0: dx = 32'h4000_0000;
					1: dx = 32'hC000_0000;
					2: dy = 32'h4000_0000;
					3: dy = 32'hC000_0000;
					4: dz = 32'h4000_0000;
					default: dz = 32'hC000_0000;
				endcase
			end
			1: begin
				for (int i = 0; i < 3; i++) dv[i] = rnd(1.0);
				norm = $sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]) + 1e-6;
				dx = $rtoi(dv[0] / norm * 1073741823.0);
				dy = $rtoi(dv[1] / norm * 1073741823.0);
				dz = $rtoi(dv[2] / norm * 1073741823.0);
			end
			default: begin
				dx = $urandom_range(1, 16); dy = 0; dz = 0;
			end
		endcase
		dmin = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'h0100_0000) : 0;
		write_ray(q16(rnd(100.0)), q16(rnd(100.0)), q16(rnd(100.0)), dx, dy, dz, dmin,
			$urandom_range(0, 40));
	endtask

	initial begin
		tb_channels_pkg::tri_item_t t;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
		tri_ch.valid = 1'b0;
		tri_ch.a_x = '0; tri_ch.a_y = '0; tri_ch.a_z = '0;
		tri_ch.b_x = '0; tri_ch.b_y = '0; tri_ch.b_z = '0;
		tri_ch.c_x = '0; tri_ch.c_y = '0; tri_ch.c_z = '0;
		tri_ch.tri_index = '0; tri_ch.last_tri = 1'b0;
		hit_ch.ready = 1'b0;
		ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
		ray_dir[0] = rmch_pkg::DIR_X_RESET; ray_dir[1] = 0; ray_dir[2] = 0;
		ray_min = '0; ray_skip = '1;
		near_valid = 0; near_dist = '0; near_index = '0; near_u = '0; near_v = '0;
		tri_in_flight = 0; tri_gap = 0; hit_stall = 0; burst = 0;
		errors = 0; tris_sent = 0; meshes_seen = 0; hits_seen = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset ray: +x from the origin, nothing skipped but index all ones
		queue_tri(make_tri(10, -1, -1, 10, 3, -1, 10, -1, 3, 5, 0));
		queue_tri(make_tri(10, -1, -1, 10, 3, -1, 10, -1, 3, 6, 0));
		queue_tri(make_tri(20, -1, -1, 20, 3, -1, 20, -1, 3, 7, 1));
		queue_tri(make_tri(-10, -1, -1, -10, 3, -1, -10, -1, 3, 1, 1));
		queue_tri(make_tri(4, 4, 4, 4, 4, 4, 4, 4, 4, 2, 0));
		queue_tri(make_tri(5, 0, 0, 5, 2, 0, 5, 0, 2, 3, 0));
		queue_tri(make_tri(8, -1, -1, 8, 3, -1, 8, -1, 3, 24'hFFFFFF, 1));
		queue_tri(make_tri(3, 0, 0, 3, 0, 2, 3, 2, 0, 9, 0));
		queue_tri(make_tri(30, -1, -1, 30, 3, -1, 30, -1, 3, 24'hFFFFFF, 1));
		t = noise_tri();
		t.a_x = 32'h7FFF_FFFF; t.a_y = 32'h7FFF_FFFF; t.a_z = 32'h7FFF_FFFF;
		t.b_x = 32'h8000_0000; t.b_y = 32'h8000_0000; t.b_z = 32'h8000_0000;
		t.c_x = 32'h7FFF_FFFF; t.c_y = 32'h8000_0000; t.c_z = 32'h7FFF_FFFF;
		t.tri_index = '0; t.last_tri = 1'b0;
		queue_tri(t);
		t.c_x = 32'h8000_0000; t.c_y = 32'h7FFF_FFFF; t.c_z = 32'h8000_0000;
		t.tri_index = 24'hFFFFFE; t.last_tri = 1'b1;
		queue_tri(t);
		queue_tri(make_tri(0.5, -1, -1, 0.5, 3, -1, 0.5, -1, 3, 4, 1));
		wait_idle();

		// extremes of the ray registers
		write_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000,
			32'h4000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		random_meshes(20);
		wait_idle();
		write_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hC000_0000, 32'hC000_0000,
			32'hC000_0000, 0, 0);
		random_meshes(20);
		wait_idle();
		// tiny direction: distances overflow
		write_ray(0, 0, 0, 1, 0, 0, 0, 32'hFFFF_FF);
		queue_tri(make_tri(1, -1, -1, 1, 3, -1, 1, -1, 3, 1, 1));
		queue_tri(make_tri(0.00001, -1, -1, 0.00001, 3, -1, 0.00001, -1, 3, 2, 1));
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			random_ray(ph % 5 == 4 ? 2 : ph % 2);
			random_meshes(105);
			wait_idle();
		end

		$display("Checked %0d mesh results over %0d triangles, %0d with a hit.",
			meshes_seen, tris_sent, hits_seen);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#80ms;
		$display("Timed out with %0d results outstanding.", expected_hits.size());
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
